FILE: rtl/tbba_pkg.sv
// ----------------------------------------------------------------------------
// tbba_pkg: shared codes and sizes
// Action codes and array sizes shared by front end, back end and checker.
// ----------------------------------------------------------------------------
package tbba_pkg;

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_START   = 2'd1;
   localparam logic [1:0] ACT_COMBINE = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   localparam int NUM_AXES = 3;
   localparam int NUM_CORNERS = 8;

endpackage

FILE: rtl/tbba_front.sv
// ----------------------------------------------------------------------------
// tbba_front: item intake and corner generation
// Holds the transform, classifies each beat and forms the 8 saturated corners
// of a combine box. Hands one registered beat to the back end per item.
// ----------------------------------------------------------------------------
module tbba_front import tbba_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [1:0]                  in_action,
   input  logic [1:0]                  in_row,
   input  logic signed [WORD_BITS-1:0] in_col [4],
   input  logic signed [WORD_BITS-1:0] in_a [NUM_AXES],
   input  logic signed [WORD_BITS-1:0] in_b [NUM_AXES],
   input  logic                        out_ready,
   output logic                        out_valid,
   output logic [1:0]                  out_action,
   output logic signed [WORD_BITS-1:0] out_a [NUM_AXES],
   output logic signed [WORD_BITS-1:0] out_b [NUM_AXES],
   output logic signed [WORD_BITS-1:0] out_corner [NUM_CORNERS][NUM_AXES],
   output logic signed [WORD_BITS-1:0] out_mat [NUM_AXES][4]
);

   localparam logic signed [WORD_BITS:0] HI = {2'b00, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS:0] LO = {2'b11, {(WORD_BITS-1){1'b0}}};

   logic signed [WORD_BITS-1:0] mat_ff [NUM_AXES][4];
   logic                        valid_ff;
   logic [1:0]                  action_ff;
   logic signed [WORD_BITS-1:0] a_ff [NUM_AXES];
   logic signed [WORD_BITS-1:0] b_ff [NUM_AXES];
   logic signed [WORD_BITS-1:0] corner_ff [NUM_CORNERS][NUM_AXES];
   logic signed [WORD_BITS-1:0] corner_in [NUM_CORNERS][NUM_AXES];
   logic signed [WORD_BITS:0]   sum;
   logic                        take;

   assign take = in_valid && (!valid_ff || out_ready);

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            if (((k >> i) & 1) != 0) begin
               sum = {in_a[i][WORD_BITS-1], in_a[i]} + {in_b[i][WORD_BITS-1], in_b[i]};
            end else begin
               sum = {in_a[i][WORD_BITS-1], in_a[i]} - {in_b[i][WORD_BITS-1], in_b[i]};
            end
            if (sum > HI) corner_in[k][i] = HI[WORD_BITS-1:0];
            else if (sum < LO) corner_in[k][i] = LO[WORD_BITS-1:0];
            else corner_in[k][i] = sum[WORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int r = 0; r < NUM_AXES; r++)
            for (int c = 0; c < 4; c++) mat_ff[r][c] <= '0;
      end else begin
         if (take) begin
            valid_ff  <= 1'b1;
            action_ff <= in_action;
            a_ff      <= in_a;
            b_ff      <= in_b;
            corner_ff <= corner_in;
            // transform updates at once; later combines see it in order
            if (in_action == ACT_LOAD && in_row < 2'd3) mat_ff[in_row] <= in_col;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_action = action_ff;
   assign out_a      = a_ff;
   assign out_b      = b_ff;
   assign out_corner = corner_ff;
   assign out_mat    = mat_ff;

endmodule

FILE: rtl/tbba_back.sv
// ----------------------------------------------------------------------------
// tbba_back: transform and bounds update
// Pipelined corner transform (multiply, round, sum, saturate), then a
// min/max merge into the running box and a result queue.
// ----------------------------------------------------------------------------
module tbba_back import tbba_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [1:0]                  in_action,
   input  logic signed [WORD_BITS-1:0] in_a [NUM_AXES],
   input  logic signed [WORD_BITS-1:0] in_b [NUM_AXES],
   input  logic signed [WORD_BITS-1:0] in_corner [NUM_CORNERS][NUM_AXES],
   input  logic signed [WORD_BITS-1:0] in_mat [NUM_AXES][4],
   input  logic                        pop,
   output logic                        empty,
   output logic signed [WORD_BITS-1:0] box_min [NUM_AXES],
   output logic signed [WORD_BITS-1:0] box_max [NUM_AXES]
);

   localparam int PW = 2 * WORD_BITS;
   localparam int SW = PW + 3;
   localparam int QDEPTH = 4;
   localparam logic [PW-1:0] CAP = PW'(64'd1 << 60);
   localparam logic signed [SW-1:0] HI = SW'((65'sd1 <<< (WORD_BITS-1)) - 65'sd1);
   localparam logic signed [SW-1:0] LO = -HI - SW'(1);

   // pipeline: s1 products, s2 rounded terms, s3 saturated sums, s4 merge
   logic                        v1_ff, v2_ff, v3_ff;
   logic [1:0]                  act1_ff, act2_ff, act3_ff;
   logic signed [WORD_BITS-1:0] a1_ff [NUM_AXES], a2_ff [NUM_AXES], a3_ff [NUM_AXES];
   logic signed [WORD_BITS-1:0] b1_ff [NUM_AXES], b2_ff [NUM_AXES], b3_ff [NUM_AXES];
   logic signed [PW-1:0]        prod_ff [NUM_CORNERS][NUM_AXES][NUM_AXES];
   logic signed [WORD_BITS-1:0] tr1_ff [NUM_AXES];
   logic signed [SW-1:0]        term_ff [NUM_CORNERS][NUM_AXES][NUM_AXES];
   logic signed [SW-1:0]        term_in [NUM_CORNERS][NUM_AXES][NUM_AXES];
   logic signed [WORD_BITS-1:0] tr2_ff [NUM_AXES];
   logic signed [WORD_BITS-1:0] pt_ff [NUM_CORNERS][NUM_AXES];
   logic signed [WORD_BITS-1:0] pt_in [NUM_CORNERS][NUM_AXES];
   logic signed [WORD_BITS-1:0] min_ff [NUM_AXES], max_ff [NUM_AXES];
   logic signed [WORD_BITS-1:0] min_in [NUM_AXES], max_in [NUM_AXES];
   logic signed [WORD_BITS-1:0] qmin_ff [QDEPTH][NUM_AXES];
   logic signed [WORD_BITS-1:0] qmax_ff [QDEPTH][NUM_AXES];
   logic [1:0]                  wp_ff, rp_ff;
   logic [2:0]                  cnt_ff, inflight;
   logic                        deq;

   // room for this beat plus everything in the pipe; a pop this cycle frees a slot
   assign inflight = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff);
   assign in_ready = ((cnt_ff + inflight) < 3'(QDEPTH)) || deq;
   assign deq      = pop && !empty;
   assign empty    = (cnt_ff == 3'd0);

   always_comb begin
      logic [PW-1:0] mag, rnd;
      logic signed [SW-1:0] s;
      for (int k = 0; k < NUM_CORNERS; k++)
         for (int i = 0; i < NUM_AXES; i++)
            for (int c = 0; c < NUM_AXES; c++) begin
               mag = prod_ff[k][i][c][PW-1] ? PW'(-prod_ff[k][i][c]) : prod_ff[k][i][c];
               rnd = (mag + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
               if (prod_ff[k][i][c] == {1'b1, {(PW-1){1'b0}}}) rnd = mag >> FRAC_BITS;
               // the cap can only bite when the product is wide enough to reach it
               if (PW > 60 && rnd > CAP) rnd = CAP;
               term_in[k][i][c] = prod_ff[k][i][c][PW-1] ? -SW'(rnd) : SW'(rnd);
            end
      for (int k = 0; k < NUM_CORNERS; k++)
         for (int i = 0; i < NUM_AXES; i++) begin
            s = SW'(tr2_ff[i]) + term_ff[k][i][0] + term_ff[k][i][1] + term_ff[k][i][2];
            if (s > HI) pt_in[k][i] = HI[WORD_BITS-1:0];
            else if (s < LO) pt_in[k][i] = LO[WORD_BITS-1:0];
            else pt_in[k][i] = s[WORD_BITS-1:0];
         end
      for (int i = 0; i < NUM_AXES; i++) begin
         min_in[i] = min_ff[i];
         max_in[i] = max_ff[i];
         if (act3_ff == ACT_START) begin
            min_in[i] = a3_ff[i];
            max_in[i] = b3_ff[i];
         end else if (act3_ff == ACT_COMBINE) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
               if (pt_ff[k][i] < min_in[i]) min_in[i] = pt_ff[k][i];
               if (pt_ff[k][i] > max_in[i]) max_in[i] = pt_ff[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else begin
         v1_ff <= in_valid && in_ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff) begin
            min_ff <= min_in;
            max_ff <= max_in;
            qmin_ff[wp_ff] <= min_in;
            qmax_ff[wp_ff] <= max_in;
            wp_ff <= wp_ff + 2'd1;
         end
         if (deq) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(v3_ff) - 3'(deq);
      end
   end

   always_ff @(posedge clock) begin
      act1_ff <= in_action;
      a1_ff   <= in_a;
      b1_ff   <= in_b;
      for (int i = 0; i < NUM_AXES; i++) begin
         tr1_ff[i] <= in_mat[i][3];
         for (int k = 0; k < NUM_CORNERS; k++)
            for (int c = 0; c < NUM_AXES; c++)
               prod_ff[k][i][c] <= PW'(in_mat[i][c]) * PW'(in_corner[k][c]);
      end
      act2_ff <= act1_ff;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      tr2_ff  <= tr1_ff;
      term_ff <= term_in;
      act3_ff <= act2_ff;
      a3_ff   <= a2_ff;
      b3_ff   <= b2_ff;
      pt_ff   <= pt_in;
   end

   assign box_min = qmin_ff[rp_ff];
   assign box_max = qmax_ff[rp_ff];

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff + inflight) <= 3'(QDEPTH))
      else $error("result queue overrun");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> (rp_ff == wp_ff))
      else $error("queue pointers disagree with count");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> v3_ff)
      else $error("pipeline lost a beat");
`endif

endmodule

FILE: rtl/transformed_box_bounds_accumulator.sv
// ----------------------------------------------------------------------------
// transformed_box_bounds_accumulator: running transformed AABB
// Front end takes items and forms corners; back end transforms and merges.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  request | req_push/req_full  | action,row,m_col0..3,vec_a_*,vec_b_*
//  result  | rsp_pop/rsp_empty  | min_x..z, max_x..z
// One item per cycle sustained while req_full stays low. A pushed item passes
// the front register, multiply, round and sum, then the min/max merge into the
// result queue, from which it can be popped.
// Synchronous reset clears transform and box to zero.
// Full rises when the front register holds a beat and the 4-entry result queue
// plus in-flight beats is full with no pop in the same cycle.
module transformed_box_bounds_accumulator import tbba_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_action,
   input  logic [1:0]                  req_row,
   input  logic signed [WORD_BITS-1:0] req_m_col0,
   input  logic signed [WORD_BITS-1:0] req_m_col1,
   input  logic signed [WORD_BITS-1:0] req_m_col2,
   input  logic signed [WORD_BITS-1:0] req_m_col3,
   input  logic signed [WORD_BITS-1:0] req_vec_a_x,
   input  logic signed [WORD_BITS-1:0] req_vec_a_y,
   input  logic signed [WORD_BITS-1:0] req_vec_a_z,
   input  logic signed [WORD_BITS-1:0] req_vec_b_x,
   input  logic signed [WORD_BITS-1:0] req_vec_b_y,
   input  logic signed [WORD_BITS-1:0] req_vec_b_z,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic signed [WORD_BITS-1:0] rsp_min_x,
   output logic signed [WORD_BITS-1:0] rsp_min_y,
   output logic signed [WORD_BITS-1:0] rsp_min_z,
   output logic signed [WORD_BITS-1:0] rsp_max_x,
   output logic signed [WORD_BITS-1:0] rsp_max_y,
   output logic signed [WORD_BITS-1:0] rsp_max_z
);

   logic                        f_valid, b_ready;
   logic [1:0]                  f_action;
   logic signed [WORD_BITS-1:0] col [4];
   logic signed [WORD_BITS-1:0] va [NUM_AXES], vb [NUM_AXES];
   logic signed [WORD_BITS-1:0] f_a [NUM_AXES], f_b [NUM_AXES];
   logic signed [WORD_BITS-1:0] f_corner [NUM_CORNERS][NUM_AXES];
   logic signed [WORD_BITS-1:0] f_mat [NUM_AXES][4];
   logic signed [WORD_BITS-1:0] bmin [NUM_AXES], bmax [NUM_AXES];

   assign col = '{req_m_col0, req_m_col1, req_m_col2, req_m_col3};
   assign va  = '{req_vec_a_x, req_vec_a_y, req_vec_a_z};
   assign vb  = '{req_vec_b_x, req_vec_b_y, req_vec_b_z};
   assign req_full = f_valid && !b_ready;

   tbba_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_push), .in_action(req_action), .in_row(req_row),
      .in_col(col), .in_a(va), .in_b(vb),
      .out_ready(b_ready), .out_valid(f_valid), .out_action(f_action),
      .out_a(f_a), .out_b(f_b), .out_corner(f_corner), .out_mat(f_mat)
   );

   tbba_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(b_ready), .in_action(f_action),
      .in_a(f_a), .in_b(f_b), .in_corner(f_corner), .in_mat(f_mat),
      .pop(rsp_pop), .empty(rsp_empty), .box_min(bmin), .box_max(bmax)
   );

   assign rsp_min_x = bmin[0];
   assign rsp_min_y = bmin[1];
   assign rsp_min_z = bmin[2];
   assign rsp_max_x = bmax[0];
   assign rsp_max_y = bmax[1];
   assign rsp_max_z = bmax[2];

endmodule

FILE: test/tbba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbba_checker: bounding box predictor and result scoreboard
// Watches accepted request and result beats, tracks the transform and the
// running box, and compares each result beat with the oldest predicted box.
// ----------------------------------------------------------------------------
module tbba_checker import tbba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_row,
   input  logic signed [31:0] req_m_col0,
   input  logic signed [31:0] req_m_col1,
   input  logic signed [31:0] req_m_col2,
   input  logic signed [31:0] req_m_col3,
   input  logic signed [31:0] req_vec_a_x,
   input  logic signed [31:0] req_vec_a_y,
   input  logic signed [31:0] req_vec_a_z,
   input  logic signed [31:0] req_vec_b_x,
   input  logic signed [31:0] req_vec_b_y,
   input  logic signed [31:0] req_vec_b_z,
   input  logic               rsp_pop,
   input  logic               rsp_empty,
   input  logic signed [31:0] rsp_min_x,
   input  logic signed [31:0] rsp_min_y,
   input  logic signed [31:0] rsp_min_z,
   input  logic signed [31:0] rsp_max_x,
   input  logic signed [31:0] rsp_max_y,
   input  logic signed [31:0] rsp_max_z,
   output int                 fail_count,
   output int                 pending_boxes
);

   typedef logic signed [31:0] word_type;
   typedef struct packed {
      word_type min_x, min_y, min_z, max_x, max_y, max_z;
   } box_type;

   localparam logic signed [127:0] WORD_HI = 128'sd2147483647;
   localparam logic signed [127:0] WORD_LO = -128'sd2147483648;
   localparam logic signed [127:0] PROD_CAP = 128'sd1 <<< 60;

   word_type xform [3][4];
   word_type run_min [3];
   word_type run_max [3];
   box_type  expected_boxes [$];

   assign pending_boxes = expected_boxes.size();

   function automatic logic signed [127:0] clamp_word(input logic signed [127:0] v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // product rounded half away from zero on magnitude, magnitude capped
   function automatic logic signed [127:0] fixed_mul(input word_type a,
                                                     input logic signed [127:0] b);
      logic signed [127:0] p;
      logic signed [127:0] mag;
      p = 128'(signed'(a)) * b;
      mag = (p < 0) ? -p : p;
      mag = (mag + (128'sd1 <<< 15)) >>> 16;
      if (mag > PROD_CAP) mag = PROD_CAP;
      return (p < 0) ? -mag : mag;
   endfunction

   task automatic merge_box(input word_type ctr [3], input word_type half [3]);
      logic signed [127:0] corner [3];
      logic signed [127:0] s;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < 3; i++) begin
            if ((k >> i) & 1)
               corner[i] = clamp_word(128'(ctr[i]) + 128'(half[i]));
            else
               corner[i] = clamp_word(128'(ctr[i]) - 128'(half[i]));
         end
         for (int i = 0; i < 3; i++) begin
            s = 128'(xform[i][3]);
            for (int c = 0; c < 3; c++) s += fixed_mul(xform[i][c], corner[c]);
            s = clamp_word(s);
            if (s < 128'(run_min[i])) run_min[i] = word_type'(s);
            if (s > 128'(run_max[i])) run_max[i] = word_type'(s);
         end
      end
   endtask

   task automatic check_field(input string name, input word_type exp_v,
                              input word_type act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      word_type a [3];
      word_type b [3];
      box_type  got;
      box_type  want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 4; c++) xform[i][c] = '0;
            run_min[i] = '0;
            run_max[i] = '0;
         end
         expected_boxes.delete();
         fail_count = 0;
      end else begin
         if (req_push && !req_full) begin
            a = '{req_vec_a_x, req_vec_a_y, req_vec_a_z};
            b = '{req_vec_b_x, req_vec_b_y, req_vec_b_z};
            case (req_action)
               ACT_LOAD: begin
                  if (req_row < 2'd3) begin
                     xform[req_row][0] = req_m_col0;
                     xform[req_row][1] = req_m_col1;
                     xform[req_row][2] = req_m_col2;
                     xform[req_row][3] = req_m_col3;
                  end
               end
               ACT_START: begin
                  run_min = a;
                  run_max = b;
               end
               ACT_COMBINE: merge_box(a, b);
               default: ;
            endcase
            expected_boxes.push_back('{run_min[0], run_min[1], run_min[2],
                                       run_max[0], run_max[1], run_max[2]});
         end
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_min_x, rsp_min_y, rsp_min_z, rsp_max_x, rsp_max_y, rsp_max_z};
            if (expected_boxes.size() == 0) begin
               $error("result beat with no box expected");
               fail_count++;
            end else begin
               want = expected_boxes.pop_front();
               check_field("min_x", want.min_x, got.min_x);
               check_field("min_y", want.min_y, got.min_y);
               check_field("min_z", want.min_z, got.min_z);
               check_field("max_x", want.max_x, got.max_x);
               check_field("max_y", want.max_y, got.max_y);
               check_field("max_z", want.max_z, got.max_z);
            end
         end
      end
   end

endmodule

FILE: test/transformed_box_bounds_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_box_bounds_accumulator_tb: top-level test
// Directed corner items, then random transform loads, box starts and box
// combines with random gaps on push and pop; a checker predicts each box.
// ----------------------------------------------------------------------------
module transformed_box_bounds_accumulator_tb;
   import tbba_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_action;
   logic [1:0]  req_row;
   logic signed [31:0] req_m_col0, req_m_col1, req_m_col2, req_m_col3;
   logic signed [31:0] req_vec_a_x, req_vec_a_y, req_vec_a_z;
   logic signed [31:0] req_vec_b_x, req_vec_b_y, req_vec_b_z;
   logic        rsp_pop;
   logic        rsp_empty;
   logic signed [31:0] rsp_min_x, rsp_min_y, rsp_min_z;
   logic signed [31:0] rsp_max_x, rsp_max_y, rsp_max_z;
   int          fail_count;
   int          pending_boxes;
   int          cycle_count;
   logic        pop_stall_off;

   transformed_box_bounds_accumulator DUT (.*);
   tbba_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly small Q16.16 values, sometimes any word or an extreme
   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return $urandom();
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || pop_stall_off) rsp_pop <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_pop <= 1'b0;
      else if (!rsp_pop && $urandom_range(0, 3) == 0) rsp_pop <= 1'b1;
      else if ($urandom_range(0, 99) == 0) rsp_pop <= 1'b0;
   end

   // push stays high across back-to-back beats; it drops only for a gap
   task automatic send_beat(input logic [1:0] act, input logic [1:0] rw,
                            input logic signed [31:0] m [4],
                            input logic signed [31:0] va [3],
                            input logic signed [31:0] vb [3], input bit idle_ok);
      int g;
      g = idle_ok ? gap_len() : 0;
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_action  <= act;
      req_row     <= rw;
      req_m_col0  <= m[0];
      req_m_col1  <= m[1];
      req_m_col2  <= m[2];
      req_m_col3  <= m[3];
      req_vec_a_x <= va[0];
      req_vec_a_y <= va[1];
      req_vec_a_z <= va[2];
      req_vec_b_x <= vb[0];
      req_vec_b_y <= vb[1];
      req_vec_b_z <= vb[2];
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_random(input logic [1:0] act, input logic [1:0] rw, input bit idle_ok);
      logic signed [31:0] m [4];
      logic signed [31:0] va [3];
      logic signed [31:0] vb [3];
      for (int i = 0; i < 4; i++) m[i] = rand_word();
      for (int i = 0; i < 3; i++) begin
         va[i] = rand_word();
         vb[i] = rand_word();
      end
      send_beat(act, rw, m, va, vb, idle_ok);
   endtask

   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam logic signed [31:0] MAXW = 32'sh7fffffff;
   localparam logic signed [31:0] MINW = 32'sh80000000;

   initial begin
      logic [1:0] act;
      logic signed [31:0] pt [3];
      cycle_count = 0;
      reset = 1'b1;
      pop_stall_off = 1'b0;
      req_push = 1'b0;
      req_action = ACT_LOAD;
      req_row = '0;
      {req_m_col0, req_m_col1, req_m_col2, req_m_col3} = '0;
      {req_vec_a_x, req_vec_a_y, req_vec_a_z} = '0;
      {req_vec_b_x, req_vec_b_y, req_vec_b_z} = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: combine with zero transform, identity, extremes, bad row/action
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{ONE, ONE, ONE}, '{ONE, ONE, ONE}, 0);
      send_beat(ACT_LOAD, 2'd0, '{ONE, 0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_LOAD, 2'd1, '{0, ONE, 0, ONE}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_LOAD, 2'd2, '{0, 0, ONE, -ONE}, '{0, 0, 0}, '{0, 0, 0}, 0);
      pt = '{32'sh0003_8000, -32'sh0002_0000, 32'sh0000_0001};
      send_beat(ACT_START, 2'd0, '{0, 0, 0, 0}, pt, pt, 0);       // start at a single point
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{ONE, -ONE, 0}, '{ONE, ONE, 32'sh8000}, 0);
      send_beat(ACT_START, 2'd0, '{0, 0, 0, 0}, '{ONE, ONE, ONE}, '{-ONE, -ONE, -ONE}, 0);
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_LOAD, 2'd3, '{MAXW, MAXW, MAXW, MAXW}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_UNUSED, 2'd0, '{MINW, MINW, MINW, MINW}, '{MAXW, MAXW, MAXW},
                '{MINW, MINW, MINW}, 0);
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{MAXW, MINW, MAXW}, '{MAXW, MAXW, MINW}, 0);
      send_beat(ACT_LOAD, 2'd0, '{MAXW, MINW, MAXW, MAXW}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_LOAD, 2'd1, '{MINW, MINW, MINW, MINW}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_LOAD, 2'd2, '{MAXW, MAXW, MAXW, MINW}, '{0, 0, 0}, '{0, 0, 0}, 0);
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{MINW, MAXW, MINW}, '{MAXW, MINW, MAXW}, 0);
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{ONE, -ONE, 32'sh1},
                '{-1, 32'sh7fff, -32'sh8000}, 0);
      send_beat(ACT_START, 2'd0, '{0, 0, 0, 0}, '{MINW, MINW, MINW}, '{MAXW, MAXW, MAXW}, 0);
      send_beat(ACT_COMBINE, 2'd0, '{0, 0, 0, 0}, '{MAXW, MAXW, MAXW}, '{MAXW, MAXW, MAXW}, 0);

      // random: mostly load/start/combine sequences, a little noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3:  act = ACT_LOAD;
            4, 5, 6:     act = ACT_START;
            19:          act = ACT_UNUSED;
            default:     act = ACT_COMBINE;
         endcase
         if (n % 300 == 150) pop_stall_off = 1'b1;
         if (n % 300 == 250) pop_stall_off = 1'b0;
         send_random(act, $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                     n % 200 >= 40);
      end
      req_push <= 1'b0;

      pop_stall_off = 1'b1;
      while (pending_boxes != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_boxes == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: transformed_box_bounds_accumulator.f
rtl/tbba_pkg.sv
rtl/tbba_front.sv
rtl/tbba_back.sv
rtl/transformed_box_bounds_accumulator.sv
test/tbba_checker.sv
test/transformed_box_bounds_accumulator_tb.sv
